/* sv/depth_to_color_gradient_assert.svh */
// Assertion macros for the depth-to-color gradient block.
`ifndef DEPTH_TO_COLOR_GRADIENT_ASSERT_SVH
`define DEPTH_TO_COLOR_GRADIENT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define DCG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcg assertion failed");
// Implication with a delay between antecedent and consequent.
`define DCG_ASSERT_DELAY5(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##5 (cons)) \
        else $error("dcg assertion failed");
`else
`define DCG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define DCG_ASSERT_DELAY5(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/dcg_pkg.sv */
// Shared types and constants for the depth-to-color gradient block.
package dcg_pkg;

    // Default values of the top-level parameters.
    localparam int DEPTH_BITS_DEF   = 11;
    localparam int PALETTE_SIZE_DEF = 4;
    localparam int FRAC_BITS_DEF    = 12;

    // Fixed field widths.
    localparam int WIN_W      = 16;
    localparam int CNT_W      = 3;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MAX_COLORS = 4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START  = 3'd0,
        REG_WINDOW_END    = 3'd1,
        REG_PALETTE_COUNT = 3'd2,
        REG_COLOR_0       = 3'd3,
        REG_COLOR_1       = 3'd4,
        REG_COLOR_2       = 3'd5,
        REG_COLOR_3       = 3'd6
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic signed [WIN_W-1:0] WINDOW_START_RST  = -16'sd1597;
    localparam logic signed [WIN_W-1:0] WINDOW_END_RST    = 16'sd8192;
    localparam logic [CNT_W-1:0]        PALETTE_COUNT_RST = 3'd4;
    localparam logic [MAX_COLORS-1:0][COLOR_W-1:0] COLOR_RST = {
        24'h03001E, 24'h7303C0, 24'hEC38BC, 24'hFDEFF9
    };

endpackage

/* sv/depth_to_color_gradient.sv */
// Depth-to-color gradient pipeline: depth sample in, interpolated RGB pixel out.
// A sample accepted at one clock edge shows its pixel with done high once it
// has passed the five register stages of the pipeline (difference, multiply,
// window add and clamp, palette select, channel blend).
// Throughput: one sample per clock; busy stays low since the receiver cannot stall.
// Reset clears every stage's valid flag and loads the default window and palette.
`include "depth_to_color_gradient_assert.svh"

module depth_to_color_gradient #(
    parameter int DEPTH_BITS   = dcg_pkg::DEPTH_BITS_DEF,
    parameter int PALETTE_SIZE = dcg_pkg::PALETTE_SIZE_DEF,
    parameter int FRAC_BITS    = dcg_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [DEPTH_BITS-1:0]             depth_sample,
    input  logic                              cfg_we,
    input  logic [dcg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcg_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              done,
    output logic [dcg_pkg::CHAN_W-1:0]        red,
    output logic [dcg_pkg::CHAN_W-1:0]        green,
    output logic [dcg_pkg::CHAN_W-1:0]        blue
);

    localparam int WIN_W   = dcg_pkg::WIN_W;
    localparam int CHAN_W  = dcg_pkg::CHAN_W;
    localparam int COLOR_W = dcg_pkg::COLOR_W;
    localparam int CNT_W   = dcg_pkg::CNT_W;
    localparam int DIFF_W  = WIN_W + 1;
    localparam int PROD_W  = DIFF_W + DEPTH_BITS + 1;
    localparam int V_W     = PROD_W - DEPTH_BITS;
    localparam int F_W     = FRAC_BITS + 1;
    localparam int P_W     = FRAC_BITS + 3;
    localparam int IDX_W   = (PALETTE_SIZE > 2) ? 2 : 1;
    localparam int ACC_W   = CHAN_W + FRAC_BITS + 3;
    localparam logic signed [V_W-1:0] ONE_V = V_W'(1) << FRAC_BITS;

    // Configuration registers.
    logic signed [WIN_W-1:0]              window_start_reg;
    logic signed [WIN_W-1:0]              window_end_reg;
    logic [CNT_W-1:0]                     palette_count_reg;
    logic [PALETTE_SIZE-1:0][COLOR_W-1:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg  <= dcg_pkg::WINDOW_START_RST;
            window_end_reg    <= dcg_pkg::WINDOW_END_RST;
            palette_count_reg <= dcg_pkg::PALETTE_COUNT_RST;
            for (int j = 0; j < PALETTE_SIZE; j++)
            begin
                color_reg[j] <= dcg_pkg::COLOR_RST[j];
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcg_pkg::REG_WINDOW_START:  window_start_reg  <= $signed(cfg_data[WIN_W-1:0]);
                dcg_pkg::REG_WINDOW_END:    window_end_reg    <= $signed(cfg_data[WIN_W-1:0]);
                dcg_pkg::REG_PALETTE_COUNT: palette_count_reg <= cfg_data[CNT_W-1:0];
                default:
                begin
                    // Color writes land only on palette entries that exist.
                    for (int j = 0; j < PALETTE_SIZE; j++)
                    begin
                        if (cfg_index == dcg_pkg::CFG_IDX_W'(int'(dcg_pkg::REG_COLOR_0) + j))
                        begin
                            color_reg[j] <= cfg_data[COLOR_W-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // Pipeline valid flags.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= s4_valid_reg;
        end
    end

    assign busy = 1'b0;
    assign done = done_reg;

    // Stage 1: capture the sample and the window span.
    logic [DEPTH_BITS-1:0]    s1_depth_reg;
    logic signed [DIFF_W-1:0] s1_span_reg;
    logic signed [DIFF_W-1:0] s1_span_next;

    assign s1_span_next = DIFF_W'(window_end_reg) - DIFF_W'(window_start_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_depth_reg <= depth_sample;
            s1_span_reg  <= s1_span_next;
        end
    end

    // Stage 2: span times depth.
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [PROD_W-1:0] s2_prod_next;

    assign s2_prod_next = PROD_W'(s1_span_reg * $signed({1'b0, s1_depth_reg}));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_prod_reg <= s2_prod_next;
        end
    end

    // Stage 3: floor divide by full scale, add the window start, clamp to 0..one.
    logic [F_W-1:0]        s3_pos_reg;
    logic [F_W-1:0]        s3_pos_next;
    logic signed [V_W-1:0] s3_v;

    always_comb
    begin
        s3_v = V_W'(window_start_reg) + V_W'(s2_prod_reg >>> DEPTH_BITS);
        if (s3_v < 0)
        begin
            s3_pos_next = '0;
        end
        else if (s3_v > ONE_V)
        begin
            s3_pos_next = F_W'(ONE_V);
        end
        else
        begin
            s3_pos_next = F_W'(s3_v);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            s3_pos_reg <= s3_pos_next;
        end
    end

    // Stage 4: scale the position by the palette span and pick two neighbors.
    logic [COLOR_W-1:0] s4_a_reg, s4_b_reg, s4_a_next, s4_b_next;
    logic [F_W-1:0]     s4_f_reg, s4_f_next;
    logic [CNT_W-1:0]   n_sat;
    logic [1:0]         n_m1;
    logic [P_W-1:0]     p_scaled;
    logic [2:0]         seg_idx;
    logic [1:0]         seg_lo;
    logic [1:0]         seg_hi;

    always_comb
    begin
        if (palette_count_reg > CNT_W'(PALETTE_SIZE))
        begin
            n_sat = CNT_W'(PALETTE_SIZE);
        end
        else
        begin
            n_sat = palette_count_reg;
        end
        n_m1     = 2'(n_sat - 1'b1);
        p_scaled = P_W'(s3_pos_reg) * P_W'(n_m1);
        seg_idx  = p_scaled[P_W-1:FRAC_BITS];
        seg_lo   = seg_idx[1:0];
        s4_f_next = F_W'(p_scaled[FRAC_BITS-1:0]);
        // The top of the range blends fully into the last color in use.
        if (seg_idx >= 3'(n_m1))
        begin
            seg_lo    = 2'(n_m1 - 1'b1);
            s4_f_next = F_W'(ONE_V);
        end
        seg_hi    = 2'(seg_lo + 1'b1);
        s4_a_next = color_reg[seg_lo[IDX_W-1:0]];
        s4_b_next = color_reg[seg_hi[IDX_W-1:0]];
        // An empty palette gives black, a single color gives color 0.
        if (n_sat == '0)
        begin
            s4_a_next = '0;
            s4_b_next = '0;
            s4_f_next = '0;
        end
        else if (n_sat == CNT_W'(1))
        begin
            s4_a_next = color_reg[0];
            s4_b_next = color_reg[0];
            s4_f_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            s4_a_reg <= s4_a_next;
            s4_b_reg <= s4_b_next;
            s4_f_reg <= s4_f_next;
        end
    end

    // Stage 5: per-channel linear blend with truncation.
    logic signed [CHAN_W:0]  ch_diff [3];
    logic signed [ACC_W-1:0] ch_acc  [3];
    logic [CHAN_W-1:0]       ch_out  [3];
    logic [CHAN_W-1:0]       red_reg, green_reg, blue_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ch_diff[k] = $signed({1'b0, s4_b_reg[CHAN_W*(2-k) +: CHAN_W]})
                       - $signed({1'b0, s4_a_reg[CHAN_W*(2-k) +: CHAN_W]});
            ch_acc[k]  = $signed(ACC_W'(s4_a_reg[CHAN_W*(2-k) +: CHAN_W]) << FRAC_BITS)
                       + ACC_W'(ch_diff[k] * $signed({1'b0, s4_f_reg}));
            ch_out[k]  = ch_acc[k][FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            red_reg   <= ch_out[0];
            green_reg <= ch_out[1];
            blue_reg  <= ch_out[2];
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // All three channels of the output beat are zero.
    logic black_px;
    assign black_px = (red == '0) && (green == '0) && (blue == '0);

    // Every accepted beat comes out with done at the end of the pipeline, and done rises for no other reason.
    `DCG_ASSERT_DELAY5(a_beat_out, clk, rst_n, start && !busy, done)
    `DCG_ASSERT_IMPLIES(a_beat_source, clk, rst_n, done, $past(start && !busy, 5))
    // An empty palette seen at the select stage yields a black pixel.
    `DCG_ASSERT_IMPLIES(a_black, clk, rst_n, done && !(|$past(palette_count_reg, 2)), black_px)

endmodule

/* dv/tb_depth_to_color_gradient.sv */
// Self-checking testbench for the depth-to-color gradient block.
`timescale 1ns / 1ps

module tb_depth_to_color_gradient;

    localparam int     DBITS          = dcg_pkg::DEPTH_BITS_DEF;
    localparam int     FRAC_BITS      = dcg_pkg::FRAC_BITS_DEF;
    localparam int     CHAN_W         = dcg_pkg::CHAN_W;
    localparam int     WIN_W          = dcg_pkg::WIN_W;
    localparam int     CNT_W          = dcg_pkg::CNT_W;
    localparam int     COLOR_W        = dcg_pkg::COLOR_W;
    localparam int     CFG_IDX_W      = dcg_pkg::CFG_IDX_W;
    localparam int     CFG_DATA_W     = dcg_pkg::CFG_DATA_W;
    localparam int     MAX_COLORS     = dcg_pkg::MAX_COLORS;
    localparam longint ONE_Q          = longint'(1) << FRAC_BITS;
    // Five pipeline stages plus margin before a register write or the end.
    localparam int     SETTLE_CYCLES  = 12;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     IDLE_PERCENT   = 27;
    // Index past the register list; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [DBITS-1:0]       depth_sample = '0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   done;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      blue;

    // Shadow copy of the configuration registers.
    logic signed [WIN_W-1:0] win_start_q;
    logic signed [WIN_W-1:0] win_end_q;
    logic [CNT_W-1:0]        count_q;
    logic [COLOR_W-1:0]      palette_q [MAX_COLORS];

    logic [DBITS-1:0] depth_queue [$];
    pixel_t           pixels_due [$];
    int               beats_queued = 0;
    int               pixels_seen = 0;
    int               mismatch_count = 0;
    int               stall_cycles = 0;
    logic             beat_taken = 1'b0;
    logic             no_gaps = 1'b0;

    depth_to_color_gradient dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .depth_sample (depth_sample),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Truncating blend of one channel between two palette entries.
    function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] lo,
                                                      input logic [CHAN_W-1:0] hi,
                                                      input longint frac);
        longint acc;
        acc = longint'(lo) * ONE_Q + (longint'(hi) - longint'(lo)) * frac;
        return CHAN_W'(acc >>> FRAC_BITS);
    endfunction

    // Expected pixel for one depth sample under the current shadow registers.
    function automatic pixel_t blend_pixel(input logic [DBITS-1:0] depth);
        longint             span_prod;
        longint             pos;
        longint             scaled;
        longint             frac;
        int unsigned        used;
        int unsigned        seg;
        logic [COLOR_W-1:0] c_lo;
        logic [COLOR_W-1:0] c_hi;
        pixel_t             px;
        used = (count_q > MAX_COLORS) ? MAX_COLORS : count_q;
        px = '0;
        if (used == 0)
        begin
            return px;
        end
        if (used == 1)
        begin
            px.red   = palette_q[0][23:16];
            px.green = palette_q[0][15:8];
            px.blue  = palette_q[0][7:0];
            return px;
        end
        // Window position, floored, then clamped to the unit range.
        span_prod = (longint'(win_end_q) - longint'(win_start_q)) * longint'(depth);
        pos = longint'(win_start_q) + (span_prod >>> DBITS);
        if (pos < 0)
        begin
            pos = 0;
        end
        if (pos > ONE_Q)
        begin
            pos = ONE_Q;
        end
        scaled = pos * longint'(used - 1);
        seg = int'(scaled >>> FRAC_BITS);
        frac = scaled & (ONE_Q - 1);
        // The top of the range is the last color, not a read past it.
        if (seg >= used - 1)
        begin
            seg = used - 2;
            frac = ONE_Q;
        end
        c_lo = palette_q[seg[1:0]];
        c_hi = palette_q[2'(seg + 1)];
        px.red   = mix_channel(c_lo[23:16], c_hi[23:16], frac);
        px.green = mix_channel(c_lo[15:8], c_hi[15:8], frac);
        px.blue  = mix_channel(c_lo[7:0], c_hi[7:0], frac);
        return px;
    endfunction

    task automatic note_mismatch(input string what, input pixel_t want, input pixel_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected r=%02h g=%02h b=%02h, got r=%02h g=%02h b=%02h",
                     $realtime, what, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
        end
    endtask

    // Write one register and mirror it; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            dcg_pkg::REG_WINDOW_START:  win_start_q = data[WIN_W-1:0];
            dcg_pkg::REG_WINDOW_END:    win_end_q = data[WIN_W-1:0];
            dcg_pkg::REG_PALETTE_COUNT: count_q = data[CNT_W-1:0];
            dcg_pkg::REG_COLOR_0:       palette_q[0] = data;
            dcg_pkg::REG_COLOR_1:       palette_q[1] = data;
            dcg_pkg::REG_COLOR_2:       palette_q[2] = data;
            dcg_pkg::REG_COLOR_3:       palette_q[3] = data;
            default:                    ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Window registers take a signed 16-bit value; the upper byte is noise.
    task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input int value);
        write_reg(idx, {8'($urandom), 16'(value)});
    endtask

    task automatic queue_depth(input logic [DBITS-1:0] d);
        depth_queue = {depth_queue, d};
        beats_queued++;
    endtask

    // Wait for every queued sample to come back, then let the pipeline settle.
    task automatic drain;
        wait (pixels_seen == beats_queued);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int beats);
        int               pick;
        logic [DBITS-1:0] d;
        // Mostly windows that land inside the gradient, some anywhere.
        if ($urandom_range(99) < 70)
        begin
            write_window(dcg_pkg::REG_WINDOW_START, int'($urandom_range(6144)) - 2048);
            write_window(dcg_pkg::REG_WINDOW_END, int'($urandom_range(10240)) - 2048);
        end
        else
        begin
            write_reg(dcg_pkg::REG_WINDOW_START, 24'($urandom));
            write_reg(dcg_pkg::REG_WINDOW_END, 24'($urandom));
        end
        pick = $urandom_range(9);
        if (pick == 0)
            write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'(0));
        else if (pick == 1)
            write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'(1));
        else if (pick == 2)
            write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'($urandom_range(7, 5)));
        else
            write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'($urandom_range(4, 2)));
        if ($urandom_range(99) < 60) write_reg(dcg_pkg::REG_COLOR_0, 24'($urandom));
        if ($urandom_range(99) < 60) write_reg(dcg_pkg::REG_COLOR_1, 24'($urandom));
        if ($urandom_range(99) < 60) write_reg(dcg_pkg::REG_COLOR_2, 24'($urandom));
        if ($urandom_range(99) < 60) write_reg(dcg_pkg::REG_COLOR_3, 24'($urandom));
        if ($urandom_range(99) < 10) write_reg(REG_UNUSED, 24'($urandom));
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                d = '0;
            else if (pick < 8)
                d = '1;
            else if (pick < 10)
                d = DBITS'(1) << (DBITS - 1);
            else
                d = DBITS'($urandom);
            queue_depth(d);
        end
        drain();
    endtask

    // Stimulus: directed phases, then random configurations with random samples.
    initial
    begin
        win_start_q = dcg_pkg::WINDOW_START_RST;
        win_end_q   = dcg_pkg::WINDOW_END_RST;
        count_q     = dcg_pkg::PALETTE_COUNT_RST;
        for (int k = 0; k < MAX_COLORS; k++)
        begin
            palette_q[k] = dcg_pkg::COLOR_RST[k];
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // Reset palette and window; the start sits below zero.
        queue_depth(0);
        queue_depth(2047);
        queue_depth(1);
        queue_depth(1024);
        queue_depth(1365);
        queue_depth(682);
        queue_depth(2046);
        drain();

        // Window 0..2: exactly one at mid scale, above one past it; extreme colors.
        write_window(dcg_pkg::REG_WINDOW_START, 0);
        write_window(dcg_pkg::REG_WINDOW_END, 8192);
        write_reg(dcg_pkg::REG_COLOR_0, 24'h000000);
        write_reg(dcg_pkg::REG_COLOR_1, 24'hFFFFFF);
        write_reg(dcg_pkg::REG_COLOR_2, 24'hFFFFFF);
        write_reg(dcg_pkg::REG_COLOR_3, 24'h000000);
        write_reg(REG_UNUSED, 24'hFFFFFF);
        queue_depth(0);
        queue_depth(512);
        queue_depth(1023);
        queue_depth(1024);
        queue_depth(1025);
        queue_depth(2047);
        drain();

        // Empty palette gives black.
        write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'(0));
        queue_depth(0);
        queue_depth(2047);
        drain();

        // Single color.
        write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'(1));
        queue_depth(1024);
        queue_depth(2047);
        drain();

        // Count above the palette saturates; windows at both extremes.
        write_reg(dcg_pkg::REG_PALETTE_COUNT, 24'(7));
        write_window(dcg_pkg::REG_WINDOW_START, -32768);
        write_window(dcg_pkg::REG_WINDOW_END, 32767);
        queue_depth(0);
        queue_depth(1024);
        queue_depth(2047);
        drain();
        write_window(dcg_pkg::REG_WINDOW_START, 32767);
        write_window(dcg_pkg::REG_WINDOW_END, -32768);
        queue_depth(0);
        queue_depth(1024);
        queue_depth(2047);
        drain();

        // Random phases; one of them runs with no idle cycles.
        for (int ph = 0; ph < 12; ph++)
        begin
            no_gaps = (ph == 5);
            random_phase(100);
        end
        no_gaps = 1'b0;

        if (mismatch_count == 0 && pixels_due.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Driver: offer the next sample at the falling edge, holding it until taken.
    always @(negedge clk)
    begin
        if (rst_n && (!start || beat_taken))
        begin
            if (depth_queue.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PERCENT))
            begin
                start        <= 1'b1;
                depth_sample <= depth_queue.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each pixel beat, then record the sample taken at this edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        pixel_t got;
        pixel_t want;
        if (!rst_n)
        begin
            beat_taken <= 1'b0;
        end
        else
        begin
            beat_taken <= start && !busy;
            if (done)
            begin
                got.red   = red;
                got.green = green;
                got.blue  = blue;
                if (pixels_due.size() == 0)
                begin
                    note_mismatch("pixel with no sample pending", '0, got);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    pixels_seen++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        note_mismatch("pixel mismatch", want, got);
                    end
                end
            end
            if (start && !busy)
            begin
                pixels_due = {pixels_due, blend_pixel(depth_sample)};
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

/* sim.f */
+incdir+sv
sv/dcg_pkg.sv
sv/depth_to_color_gradient.sv
dv/tb_depth_to_color_gradient.sv
